@@ design/kgsr_pkg.sv @@
// ----------------------------------------------------------------------------
// K-group stream reverser package
// Shared widths and control codes for the group reverser and its cell chain.
// ----------------------------------------------------------------------------
package kgsr_pkg;

    localparam int MAX_GROUP  = 64;
    localparam int DATA_WIDTH = 16;
    localparam int COUNT_W    = $clog2(MAX_GROUP + 1);

    typedef logic [DATA_WIDTH-1:0] word_t;
    typedef logic [COUNT_W-1:0]    count_t;

    // shift direction for the whole chain
    typedef enum logic [1:0] {
        OP_HOLD,
        OP_UP,
        OP_DOWN
    } chain_op_t;

    typedef struct packed {
        chain_op_t op;
        word_t     in_word;
    } chain_ctrl_t;

    typedef enum logic [1:0] {
        ST_FILL,
        ST_ALIGN,
        ST_DRAIN_REV,
        ST_DRAIN_FWD
    } state_t;

endpackage

@@ design/kgsr_cell.sv @@
// ----------------------------------------------------------------------------
// K-group reverser cell
// One word of storage that takes the word of its lower or upper neighbor.
// ----------------------------------------------------------------------------
module kgsr_cell (
    input  logic               aclk,
    input  kgsr_pkg::chain_op_t op,
    input  kgsr_pkg::word_t    lower_word,
    input  kgsr_pkg::word_t    upper_word,
    output kgsr_pkg::word_t    word
);
    import kgsr_pkg::*;

    word_t word_reg;

    always_ff @(posedge aclk) begin
        case (op)
            OP_UP:   word_reg <= lower_word;
            OP_DOWN: word_reg <= upper_word;
            default: word_reg <= word_reg;
        endcase
    end

    assign word = word_reg;

endmodule

@@ design/kgsr_chain.sv @@
// ----------------------------------------------------------------------------
// K-group reverser cell chain
// Row of cells shifting up on push and down on pop, open at both ends.
// ----------------------------------------------------------------------------
module kgsr_chain (
    input  logic                  aclk,
    input  kgsr_pkg::chain_ctrl_t ctrl,
    output kgsr_pkg::word_t       bottom_word,
    output kgsr_pkg::word_t       top_word
);
    import kgsr_pkg::*;

    word_t cell_word [MAX_GROUP];

    for (genvar i = 0; i < MAX_GROUP; i++) begin : g_cell
        word_t lower_w;
        word_t upper_w;

        if (i == 0) begin : g_bottom
            assign lower_w = ctrl.in_word;
        end else begin : g_lower
            assign lower_w = cell_word[i-1];
        end

        if (i == MAX_GROUP - 1) begin : g_top
            assign upper_w = '0;
        end else begin : g_upper
            assign upper_w = cell_word[i+1];
        end

        kgsr_cell u_cell (
            .aclk       (aclk),
            .op         (ctrl.op),
            .lower_word (lower_w),
            .upper_word (upper_w),
            .word       (cell_word[i])
        );
    end

    assign bottom_word = cell_word[0];
    assign top_word    = cell_word[MAX_GROUP-1];

endmodule

@@ design/k_group_stream_reverser.sv @@
// ----------------------------------------------------------------------------
// K-group stream reverser
// Collects words into groups of group_size and sends each group reversed;
// a partial group closed by list end goes out in arrival order.
// ----------------------------------------------------------------------------
// Usage:
//   Input words arrive on s_valid/s_ready with s_data_word and s_list_end.
//   Results leave on m_valid/m_ready with m_out_word, m_run_last (last word
//   caused by one input word) and m_list_last (last word of a list).
//   group_size is written through cfg_wr_en/cfg_wr_data while idle; 0 acts
//   as 1 and values above 64 act as 64.
// Throughput and order:
//   Words are taken one per cycle while a group fills. The word that
//   completes a group starts a drain, one word per cycle while the
//   receiver keeps up, from the bottom of a 64-cell shift chain; the first
//   result is registered once the drain has begun and the output register
//   is free. A partial group closed by list end is first shifted up until
//   its oldest word is in the top cell, then drains from the top. No input is taken while draining.
// Reset and stall:
//   Reset empties the group, clears the output valid flag and sets group_size
//   to 1. A stalled receiver holds the output word and pauses the drain.
// ----------------------------------------------------------------------------
module k_group_stream_reverser (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [6:0]            cfg_wr_data,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  kgsr_pkg::word_t       s_data_word,
    input  logic                  s_list_end,
    output logic                  m_valid,
    input  logic                  m_ready,
    output kgsr_pkg::word_t       m_out_word,
    output logic                  m_run_last,
    output logic                  m_list_last
);
    import kgsr_pkg::*;

    state_t      state_reg, state_next;
    count_t      fill_cnt_reg, fill_cnt_next;
    count_t      rem_cnt_reg, rem_cnt_next;
    count_t      step_cnt_reg, step_cnt_next;
    logic        end_reg, end_next;
    logic [6:0]  cfg_size_reg;
    logic        m_valid_reg, m_valid_next;
    word_t       m_word_reg, m_word_next;
    logic        m_run_last_reg, m_run_last_next;
    logic        m_list_last_reg, m_list_last_next;

    count_t      eff_size;
    count_t      fill_inc;
    logic        last_word;
    chain_ctrl_t chain_ctrl;
    word_t       bottom_word;
    word_t       top_word;

    kgsr_chain u_chain (
        .aclk        (aclk),
        .ctrl        (chain_ctrl),
        .bottom_word (bottom_word),
        .top_word    (top_word)
    );

    always_comb begin
        if (cfg_size_reg == 7'd0) begin
            eff_size = count_t'(1);
        end else if ({1'b0, cfg_size_reg} > 8'(MAX_GROUP)) begin
            eff_size = count_t'(MAX_GROUP);
        end else begin
            eff_size = count_t'(cfg_size_reg);
        end
    end

    assign fill_inc  = fill_cnt_reg + count_t'(1);
    assign last_word = (rem_cnt_reg == count_t'(1));

    always_comb begin
        state_next       = state_reg;
        fill_cnt_next    = fill_cnt_reg;
        rem_cnt_next     = rem_cnt_reg;
        step_cnt_next    = step_cnt_reg;
        end_next         = end_reg;
        m_valid_next     = m_valid_reg;
        m_word_next      = m_word_reg;
        m_run_last_next  = m_run_last_reg;
        m_list_last_next = m_list_last_reg;
        chain_ctrl.op      = OP_HOLD;
        chain_ctrl.in_word = s_data_word;

        if (m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_FILL: begin
                if (s_valid) begin
                    chain_ctrl.op = OP_UP;
                    end_next      = s_list_end;
                    if (fill_inc >= eff_size) begin
                        fill_cnt_next = '0;
                        rem_cnt_next  = fill_inc;
                        state_next    = ST_DRAIN_REV;
                    end else if (s_list_end) begin
                        fill_cnt_next = '0;
                        rem_cnt_next  = fill_inc;
                        step_cnt_next = count_t'(MAX_GROUP) - fill_inc;
                        state_next    = ST_ALIGN;
                    end else begin
                        fill_cnt_next = fill_inc;
                    end
                end
            end
            ST_ALIGN: begin
                chain_ctrl.op = OP_UP;
                step_cnt_next = step_cnt_reg - count_t'(1);
                if (step_cnt_reg == count_t'(1)) begin
                    state_next = ST_DRAIN_FWD;
                end
            end
            ST_DRAIN_REV, ST_DRAIN_FWD: begin
                if (!m_valid_reg || m_ready) begin
                    if (state_reg == ST_DRAIN_REV) begin
                        chain_ctrl.op = OP_DOWN;
                        m_word_next   = bottom_word;
                    end else begin
                        chain_ctrl.op = OP_UP;
                        m_word_next   = top_word;
                    end
                    m_valid_next     = 1'b1;
                    m_run_last_next  = last_word;
                    m_list_last_next = last_word && end_reg;
                    rem_cnt_next     = rem_cnt_reg - count_t'(1);
                    if (last_word) begin
                        state_next = ST_FILL;
                    end
                end
            end
            default: begin
                state_next = ST_FILL;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_FILL;
            fill_cnt_reg <= '0;
            rem_cnt_reg  <= '0;
            step_cnt_reg <= '0;
            end_reg      <= 1'b0;
            cfg_size_reg <= 7'd1;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            fill_cnt_reg <= fill_cnt_next;
            rem_cnt_reg  <= rem_cnt_next;
            step_cnt_reg <= step_cnt_next;
            end_reg      <= end_next;
            m_valid_reg  <= m_valid_next;
            if (cfg_wr_en) begin
                cfg_size_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        m_word_reg      <= m_word_next;
        m_run_last_reg  <= m_run_last_next;
        m_list_last_reg <= m_list_last_next;
    end

    assign s_ready     = (state_reg == ST_FILL);
    assign m_valid     = m_valid_reg;
    assign m_out_word  = m_word_reg;
    assign m_run_last  = m_run_last_reg;
    assign m_list_last = m_list_last_reg;

    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_cnt_reg < count_t'(MAX_GROUP))
        else $error("group fill count out of range");

    a_drain_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DRAIN_REV || state_reg == ST_DRAIN_FWD) |-> rem_cnt_reg != '0)
        else $error("drain with no words left");

    a_end_drains: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_list_end) |=> state_reg != ST_FILL)
        else $error("list end did not start a drain");

    a_list_last_run: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_list_last) |-> m_run_last)
        else $error("list_last without run_last");

endmodule
